// File: rtl/frr_pkg.sv
// shared types, codes and constants of the file request receiver
package frr_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// control characters of the exchange
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_ENQ = 8'h05;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_ETB = 8'h17;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_SUB = 8'h1a;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] TIMER_MAX = 16'hffff;

	// register reset values
	localparam logic        RST_REFUSE     = 1'b0;
	localparam logic [15:0] RST_ENQ_RESEND = 16'd200;
	localparam logic [15:0] RST_WAIT_LIMIT = 16'd2000;
	localparam logic [15:0] RST_BYTE_TMO   = 16'd200;
	localparam logic [15:0] RST_START_LIM  = 16'd1500;
	localparam logic [15:0] RST_START_ACK  = 16'd300;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_TICK    = 3'd1,
		KIND_CARRIER = 3'd2,
		KIND_START   = 3'd3,
		KIND_FINISH  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ACT_SEND     = 3'd0,
		ACT_REQ_BYTE = 3'd1,
		ACT_GOOD     = 3'd2,
		ACT_DISCARD  = 3'd3,
		ACT_SERVE    = 3'd4,
		ACT_END      = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_SUCCESS = 2'd0,
		ST_CARRIER = 2'd1,
		ST_TIMEOUT = 2'd2
	} end_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFUSE     = 3'd0,
		REG_ENQ_RESEND = 3'd1,
		REG_WAIT_LIMIT = 3'd2,
		REG_BYTE_TMO   = 3'd3,
		REG_START_LIM  = 3'd4,
		REG_START_ACK  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  byte_value;
		end_status_t end_status;
	} result_t;

	// all results caused by one input beat
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic result_t mk_result(action_t act, logic [7:0] b, end_status_t st);
		result_t r;
		r.action     = act;
		r.byte_value = b;
		r.end_status = st;
		return r;
	endfunction

endpackage

// File: rtl/frr_if.sv
// channel interfaces: request events, result beats, register writes
interface frr_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface frr_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] byte_value;
	logic [1:0] end_status;
	logic       last;

	modport source (output valid, output action, output byte_value, output end_status,
		output last, input ready);
	modport sink (input valid, input action, input byte_value, input end_status,
		input last, output ready);
endinterface

interface frr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/file_request_receiver.sv
// top level of the file request receiver
//
//  channel  role   beat carries
//  req      sink   kind, rx_byte (byte, tick, carrier lost, start, finished)
//  rsp      source action, byte_value, end_status, last
//  cfg      sink   index, data (register write, always ready)
//
// one request event is taken per cycle; the session state, timers and crc
// update in the cycle of the beat, so one event follows the next directly.
// each event yields zero to two result beats, one per cycle on rsp while rsp.ready is high,
// so a run of events with two results each is held back by the output rather than by req.
// req stalls only when the QUEUE_DEPTH-entry result queue is full.
// reset brings the session to idle with the registers at their defaults.
module file_request_receiver import frr_pkg::*; #(
	parameter int unsigned MAX_REQUEST_LEN = 100,
	parameter int unsigned QUEUE_DEPTH     = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	frr_req_if.sink   req,
	frr_rsp_if.source rsp,
	frr_cfg_if.sink   cfg
);

	logic        q_push;
	logic        q_pop;
	pair_t       q_in;
	pair_t       q_head;
	queue_stat_t q_stat;

	frr_engine #(
		.MAX_REQUEST_LEN(MAX_REQUEST_LEN)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.q_full   (q_stat.full),
		.push     (q_push),
		.push_data(q_in)
	);

	frr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	frr_drain u_drain (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (q_head),
		.q_stat(q_stat),
		.pop   (q_pop),
		.rsp   (rsp)
	);

`ifndef NO_ASSERTIONS
	// a group is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("result group pushed into full queue");

	// the second beat of a group is ready right after the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && !rsp.last) |=> rsp.valid)
		else $error("second beat of result group missing");

	// a pop only happens with something in the queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// a status code is only carried by a session end
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.end_status != ST_SUCCESS) |-> rsp.action == ACT_END)
		else $error("end status on a beat that is not a session end");
`endif

endmodule

// File: rtl/frr_engine.sv
// front end: registers, session state machine, timers and frame crc
module frr_engine import frr_pkg::*; #(
	parameter int unsigned MAX_REQUEST_LEN = 100
) (
	input  logic          clk,
	input  logic          arst_n,
	frr_req_if.sink       req,
	frr_cfg_if.sink       cfg,
	input  logic          q_full,
	output logic          push,
	output pair_t         push_data
);

	localparam int unsigned CNT_W = $clog2(MAX_REQUEST_LEN + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUEST_LEN);

	typedef enum logic [6:0] {
		PH_IDLE       = 7'b0000001,
		PH_WAIT_BARK  = 7'b0000010,
		PH_FRAME      = 7'b0000100,
		PH_CRC_LO     = 7'b0001000,
		PH_CRC_HI     = 7'b0010000,
		PH_WAIT_START = 7'b0100000,
		PH_SERVING    = 7'b1000000
	} phase_t;

	logic        refuse_q;
	logic [15:0] enq_resend_q, wait_limit_q, byte_tmo_q, start_lim_q, start_ack_q;

	phase_t           phase_q, phase_d;
	logic [15:0]      resend_q, resend_d;
	logic [15:0]      ptimer_q, ptimer_d;
	logic [15:0]      gap_q, gap_d;
	logic [15:0]      crc_q, crc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       crc_lo_q, crc_lo_d;

	logic        acc;
	kind_t       kind;
	logic [7:0]  b;
	result_t     res_c [2];
	logic [1:0]  n_c;
	logic        do_round, do_discard;
	logic [15:0] ptimer_inc, resend_inc, gap_inc;

	function automatic logic [15:0] bump(input logic [15:0] t);
		return (t == TIMER_MAX) ? t : t + 16'd1;
	endfunction

	// a limit of zero behaves like one
	function automatic logic reached(input logic [15:0] t, input logic [15:0] lim);
		return t >= ((lim == 16'd0) ? 16'd1 : lim);
	endfunction

	function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] d);
		logic [15:0] c;
		c = crc_in ^ {d, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	assign cfg.ready = 1'b1;
	assign req.ready = !q_full;
	assign acc       = req.valid && req.ready;
	assign kind      = kind_t'(req.kind);
	assign b         = req.rx_byte;

	assign ptimer_inc = bump(ptimer_q);
	assign resend_inc = bump(resend_q);
	assign gap_inc    = bump(gap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refuse_q     <= RST_REFUSE;
			enq_resend_q <= RST_ENQ_RESEND;
			wait_limit_q <= RST_WAIT_LIMIT;
			byte_tmo_q   <= RST_BYTE_TMO;
			start_lim_q  <= RST_START_LIM;
			start_ack_q  <= RST_START_ACK;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_REFUSE:     refuse_q     <= cfg.data[0];
				REG_ENQ_RESEND: enq_resend_q <= cfg.data;
				REG_WAIT_LIMIT: wait_limit_q <= cfg.data;
				REG_BYTE_TMO:   byte_tmo_q   <= cfg.data;
				REG_START_LIM:  start_lim_q  <= cfg.data;
				REG_START_ACK:  start_ack_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d    = phase_q;
		resend_d   = resend_q;
		ptimer_d   = ptimer_q;
		gap_d      = gap_q;
		crc_d      = crc_q;
		cnt_d      = cnt_q;
		crc_lo_d   = crc_lo_q;
		res_c[0]   = '0;
		res_c[1]   = '0;
		n_c        = 2'd0;
		do_round   = 1'b0;
		do_discard = 1'b0;

		unique case (kind)
			KIND_BYTE: begin
				unique case (phase_q)
					PH_WAIT_BARK: begin
						if (b == CH_ACK) begin
							phase_d = PH_FRAME;
							crc_d   = '0;
							cnt_d   = '0;
							gap_d   = '0;
						end else if (b == CH_ETB) begin
							res_c[n_c[0]] = mk_result(ACT_END, 8'h00, ST_SUCCESS);
							n_c = n_c + 2'd1;
							phase_d = PH_IDLE;
						end else if (b == CH_ENQ) begin
							res_c[n_c[0]] = mk_result(ACT_SEND, CH_ETB, ST_SUCCESS);
							n_c = n_c + 2'd1;
						end
					end
					PH_FRAME: begin
						gap_d = '0;
						// a leading ack is a repeat of the opener
						if (!(b == CH_ACK && cnt_q == '0)) begin
							if (cnt_q >= CNT_MAX) begin
								do_discard = 1'b1;
							end else if (b == CH_ETX) begin
								phase_d = PH_CRC_LO;
							end else if (b == CH_SUB) begin
								do_discard = 1'b1;
							end else begin
								res_c[n_c[0]] = mk_result(ACT_REQ_BYTE, b, ST_SUCCESS);
								n_c = n_c + 2'd1;
								crc_d = crc_step(crc_q, b);
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
					end
					PH_CRC_LO: begin
						gap_d    = '0;
						crc_lo_d = b;
						phase_d  = PH_CRC_HI;
					end
					PH_CRC_HI: begin
						if ({b, crc_lo_q} == crc_q) begin
							res_c[0] = mk_result(ACT_GOOD, 8'h00, ST_SUCCESS);
							res_c[1] = mk_result(ACT_SEND, CH_ACK, ST_SUCCESS);
							n_c      = 2'd2;
							phase_d  = PH_WAIT_START;
							ptimer_d = '0;
							gap_d    = '0;
						end else begin
							do_discard = 1'b1;
						end
					end
					PH_WAIT_START: begin
						if (b == CH_C || b == CH_NAK) begin
							res_c[n_c[0]] = mk_result(ACT_SERVE, 8'h00, ST_SUCCESS);
							n_c = n_c + 2'd1;
							phase_d = PH_SERVING;
						end else begin
							gap_d = '0;
						end
					end
					default: ;
				endcase
			end
			KIND_TICK: begin
				unique case (phase_q)
					PH_WAIT_BARK: begin
						ptimer_d = ptimer_inc;
						resend_d = resend_inc;
						// the give-up limit wins over a resend
						if (reached(ptimer_inc, wait_limit_q)) begin
							res_c[n_c[0]] = mk_result(ACT_END, 8'h00, ST_TIMEOUT);
							n_c = n_c + 2'd1;
							phase_d = PH_IDLE;
						end else if (reached(resend_inc, enq_resend_q)) begin
							res_c[n_c[0]] = mk_result(ACT_SEND, CH_ENQ, ST_SUCCESS);
							n_c = n_c + 2'd1;
							resend_d = '0;
						end
					end
					PH_FRAME, PH_CRC_LO, PH_CRC_HI: begin
						gap_d = gap_inc;
						if (reached(gap_inc, byte_tmo_q)) begin
							do_discard = 1'b1;
						end
					end
					PH_WAIT_START: begin
						ptimer_d = ptimer_inc;
						gap_d    = gap_inc;
						if (reached(ptimer_inc, start_lim_q)) begin
							res_c[n_c[0]] = mk_result(ACT_END, 8'h00, ST_TIMEOUT);
							n_c = n_c + 2'd1;
							phase_d = PH_IDLE;
						end else if (reached(gap_inc, start_ack_q)) begin
							res_c[n_c[0]] = mk_result(ACT_SEND, CH_ACK, ST_SUCCESS);
							n_c = n_c + 2'd1;
							gap_d = '0;
						end
					end
					default: ;
				endcase
			end
			KIND_CARRIER: begin
				if (phase_q == PH_FRAME || phase_q == PH_CRC_LO || phase_q == PH_CRC_HI) begin
					res_c[n_c[0]] = mk_result(ACT_DISCARD, 8'h00, ST_SUCCESS);
					n_c = n_c + 2'd1;
				end
				if (phase_q != PH_IDLE) begin
					res_c[n_c[0]] = mk_result(ACT_END, 8'h00, ST_CARRIER);
					n_c = n_c + 2'd1;
					phase_d = PH_IDLE;
				end
			end
			KIND_START: begin
				if (phase_q == PH_IDLE) do_round = 1'b1;
			end
			KIND_FINISH: begin
				if (phase_q == PH_SERVING) do_round = 1'b1;
			end
			default: ;
		endcase

		// a discard is reported unless refusing; then a new round opens, or the refusal is sent
		if (do_discard && !refuse_q) begin
			res_c[n_c[0]] = mk_result(ACT_DISCARD, 8'h00, ST_SUCCESS);
			n_c = n_c + 2'd1;
		end
		if (do_discard || do_round) begin
			if (refuse_q) begin
				res_c[0] = mk_result(ACT_SEND, CH_CAN, ST_SUCCESS);
				res_c[1] = mk_result(ACT_END, 8'h00, ST_SUCCESS);
				n_c      = 2'd2;
				phase_d  = PH_IDLE;
			end else begin
				res_c[n_c[0]] = mk_result(ACT_SEND, CH_ENQ, ST_SUCCESS);
				n_c = n_c + 2'd1;
				phase_d  = PH_WAIT_BARK;
				resend_d = '0;
				ptimer_d = '0;
			end
		end
	end

	assign push         = acc && (n_c != 2'd0);
	assign push_data.two = n_c[1];
	assign push_data.r0  = res_c[0];
	assign push_data.r1  = res_c[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			resend_q <= '0;
			ptimer_q <= '0;
			gap_q    <= '0;
			crc_q    <= '0;
			cnt_q    <= '0;
			crc_lo_q <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			resend_q <= resend_d;
			ptimer_q <= ptimer_d;
			gap_q    <= gap_d;
			crc_q    <= crc_d;
			cnt_q    <= cnt_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

// File: rtl/frr_queue.sv
// short queue of result groups between front end and back end
module frr_queue import frr_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pair_t       push_data,
	input  logic        pop,
	output pair_t       head,
	output queue_stat_t stat
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pair_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: rtl/frr_drain.sv
// back end: output register that sends each result group as one or two beats
module frr_drain import frr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  pair_t         head,
	input  queue_stat_t   q_stat,
	output logic          pop,
	frr_rsp_if.source     rsp
);

	pair_t   pair_q;
	logic    have_q;
	logic    sel_q;
	result_t cur;
	logic    beat;
	logic    finish;

	assign cur            = sel_q ? pair_q.r1 : pair_q.r0;
	assign rsp.valid      = have_q;
	assign rsp.action     = cur.action;
	assign rsp.byte_value = cur.byte_value;
	assign rsp.end_status = cur.end_status;
	assign rsp.last       = sel_q || !pair_q.two;

	assign beat   = rsp.valid && rsp.ready;
	assign finish = beat && rsp.last;
	// refill in the same cycle the last beat of a group leaves
	assign pop    = !q_stat.empty && (!have_q || finish);

	always_ff @(posedge clk) begin
		if (pop) pair_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			sel_q  <= 1'b0;
		end else if (pop) begin
			have_q <= 1'b1;
			sel_q  <= 1'b0;
		end else if (finish) begin
			have_q <= 1'b0;
			sel_q  <= 1'b0;
		end else if (beat) begin
			sel_q <= 1'b1;
		end
	end

endmodule

// File: test/file_request_receiver_test.sv
// self-checking testbench of the file request receiver: directed sessions, then random traffic
module file_request_receiver_test;
	import frr_pkg::*;

	localparam int unsigned REQ_MAX       = 100;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned RANDOM_UNTIL  = 1100;
	localparam int unsigned STEADY_UNTIL  = 1250;

	// kind codes with no meaning to the block
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT_BARK,
		S_FRAME,
		S_CRC_LO,
		S_CRC_HI,
		S_WAIT_START,
		S_SERVING
	} sess_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  byte_value;
		end_status_t end_status;
		logic        last;
	} rsp_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	frr_req_if req();
	frr_rsp_if rsp();
	frr_cfg_if cfg();

	file_request_receiver #(
		.MAX_REQUEST_LEN(REQ_MAX)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register shadow
	logic        reg_refuse     = RST_REFUSE;
	logic [15:0] reg_enq_resend = RST_ENQ_RESEND;
	logic [15:0] reg_wait_limit = RST_WAIT_LIMIT;
	logic [15:0] reg_byte_tmo   = RST_BYTE_TMO;
	logic [15:0] reg_start_lim  = RST_START_LIM;
	logic [15:0] reg_start_ack  = RST_START_ACK;

	// session state of the predictor
	sess_t       sess        = S_IDLE;
	logic [15:0] resend_cnt  = '0;
	logic [15:0] wait_cnt    = '0;
	logic [15:0] gap_cnt     = '0;
	logic [15:0] frame_crc   = '0;
	logic [6:0]  frame_len   = '0;
	logic [7:0]  crc_lo_seen = '0;

	rsp_beat_t burst[$];
	rsp_beat_t expected_rsp[$];

	int unsigned errors      = 0;
	int unsigned n_events    = 0;
	int unsigned n_results   = 0;
	int unsigned n_writes    = 0;
	int unsigned n_good      = 0;
	int unsigned n_discard   = 0;
	int unsigned n_serve     = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	logic        idle_mode   = 1'b1;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic logic [15:0] tick_up(input logic [15:0] t);
		return (t == TIMER_MAX) ? t : t + 16'd1;
	endfunction

	// a limit of zero behaves like one
	function automatic logic timer_due(input logic [15:0] t, input logic [15:0] lim);
		return t >= ((lim == 16'd0) ? 16'd1 : lim);
	endfunction

	function automatic void add_beat(input action_t a, input logic [7:0] b, input end_status_t s);
		rsp_beat_t r;
		r.action     = a;
		r.byte_value = b;
		r.end_status = s;
		r.last       = 1'b0;
		burst.push_back(r);
	endfunction

	function automatic void open_round();
		if (reg_refuse) begin
			add_beat(ACT_SEND, CH_CAN, ST_SUCCESS);
			add_beat(ACT_END, 8'h00, ST_SUCCESS);
			sess = S_IDLE;
		end else begin
			add_beat(ACT_SEND, CH_ENQ, ST_SUCCESS);
			sess       = S_WAIT_BARK;
			resend_cnt = '0;
			wait_cnt   = '0;
		end
	endfunction

	// a refusing receiver gives no discard beat, only the refusal
	function automatic void drop_frame();
		if (!reg_refuse)
			add_beat(ACT_DISCARD, 8'h00, ST_SUCCESS);
		open_round();
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		case (sess)
		S_WAIT_BARK: begin
			if (b == CH_ACK) begin
				sess      = S_FRAME;
				frame_crc = '0;
				frame_len = '0;
				gap_cnt   = '0;
			end else if (b == CH_ETB) begin
				add_beat(ACT_END, 8'h00, ST_SUCCESS);
				sess = S_IDLE;
			end else if (b == CH_ENQ) begin
				add_beat(ACT_SEND, CH_ETB, ST_SUCCESS);
			end
		end
		S_FRAME: begin
			gap_cnt = '0;
			// leading ack of a frame is dropped
			if (!(b == CH_ACK && frame_len == 0)) begin
				if (frame_len >= REQ_MAX) begin
					drop_frame();
				end else if (b == CH_ETX) begin
					sess = S_CRC_LO;
				end else if (b == CH_SUB) begin
					drop_frame();
				end else begin
					add_beat(ACT_REQ_BYTE, b, ST_SUCCESS);
					frame_crc = crc_update(frame_crc, b);
					frame_len = frame_len + 7'd1;
				end
			end
		end
		S_CRC_LO: begin
			gap_cnt     = '0;
			crc_lo_seen = b;
			sess        = S_CRC_HI;
		end
		S_CRC_HI: begin
			if ({b, crc_lo_seen} == frame_crc) begin
				add_beat(ACT_GOOD, 8'h00, ST_SUCCESS);
				add_beat(ACT_SEND, CH_ACK, ST_SUCCESS);
				sess     = S_WAIT_START;
				wait_cnt = '0;
				gap_cnt  = '0;
			end else begin
				drop_frame();
			end
		end
		S_WAIT_START: begin
			if (b == CH_C || b == CH_NAK) begin
				add_beat(ACT_SERVE, 8'h00, ST_SUCCESS);
				sess = S_SERVING;
			end else begin
				gap_cnt = '0;
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void predict_tick();
		case (sess)
		S_WAIT_BARK: begin
			wait_cnt   = tick_up(wait_cnt);
			resend_cnt = tick_up(resend_cnt);
			if (timer_due(wait_cnt, reg_wait_limit)) begin
				add_beat(ACT_END, 8'h00, ST_TIMEOUT);
				sess = S_IDLE;
			end else if (timer_due(resend_cnt, reg_enq_resend)) begin
				add_beat(ACT_SEND, CH_ENQ, ST_SUCCESS);
				resend_cnt = '0;
			end
		end
		S_FRAME, S_CRC_LO, S_CRC_HI: begin
			gap_cnt = tick_up(gap_cnt);
			if (timer_due(gap_cnt, reg_byte_tmo))
				drop_frame();
		end
		S_WAIT_START: begin
			wait_cnt = tick_up(wait_cnt);
			gap_cnt  = tick_up(gap_cnt);
			if (timer_due(wait_cnt, reg_start_lim)) begin
				add_beat(ACT_END, 8'h00, ST_TIMEOUT);
				sess = S_IDLE;
			end else if (timer_due(gap_cnt, reg_start_ack)) begin
				add_beat(ACT_SEND, CH_ACK, ST_SUCCESS);
				gap_cnt = '0;
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void predict_event(input logic [2:0] k, input logic [7:0] b);
		case (k)
		KIND_BYTE: predict_byte(b);
		KIND_TICK: predict_tick();
		KIND_CARRIER: begin
			if (sess inside {S_FRAME, S_CRC_LO, S_CRC_HI})
				add_beat(ACT_DISCARD, 8'h00, ST_SUCCESS);
			if (sess != S_IDLE) begin
				add_beat(ACT_END, 8'h00, ST_CARRIER);
				sess = S_IDLE;
			end
		end
		KIND_START: if (sess == S_IDLE) open_round();
		KIND_FINISH: if (sess == S_SERVING) open_round();
		default: ;
		endcase
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		while (burst.size() != 0)
			expected_rsp.push_back(burst.pop_front());
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] d);
		case (idx)
		REG_REFUSE:     reg_refuse     = d[0];
		REG_ENQ_RESEND: reg_enq_resend = d;
		REG_WAIT_LIMIT: reg_wait_limit = d;
		REG_BYTE_TMO:   reg_byte_tmo   = d;
		REG_START_LIM:  reg_start_lim  = d;
		REG_START_ACK:  reg_start_ack  = d;
		default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_v,
		input int unsigned got_v);
		errors++;
		$display("mismatch at result beat %0d: %s expected %0d got %0d",
			n_results, what, exp_v, got_v);
	endtask

	task automatic check_beat();
		rsp_beat_t want;
		if (expected_rsp.size() == 0) begin
			report_mismatch("beat with nothing pending, action", 0, 32'(rsp.action));
		end else begin
			want = expected_rsp.pop_front();
			if (rsp.action !== want.action)
				report_mismatch("action", 32'(want.action), 32'(rsp.action));
			if (rsp.byte_value !== want.byte_value)
				report_mismatch("byte_value", 32'(want.byte_value), 32'(rsp.byte_value));
			if (rsp.end_status !== want.end_status)
				report_mismatch("end_status", 32'(want.end_status), 32'(rsp.end_status));
			if (rsp.last !== want.last)
				report_mismatch("last", 32'(want.last), 32'(rsp.last));
		end
		n_results++;
		case (rsp.action)
		ACT_GOOD:    n_good++;
		ACT_DISCARD: n_discard++;
		ACT_SERVE:   n_serve++;
		default: ;
		endcase
	endtask

	// prediction first, then the check of any result beat taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				apply_reg(cfg.index, cfg.data);
				n_writes++;
			end
			if (req.valid && req.ready)
				predict_event(req.kind, req.rx_byte);
			if (rsp.valid && rsp.ready)
				check_beat();
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_mode && $urandom_range(0, 7) == 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("file_request_receiver regression: fail");
			$finish;
		end
	end

	task automatic send_event(input logic [2:0] k, input logic [7:0] b);
		if (idle_mode && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.kind    <= k;
		req.rx_byte <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_events++;
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_event(KIND_TICK, 8'($urandom));
	endtask

	task automatic send_noise(input int unsigned n);
		repeat (n) send_event(3'($urandom), 8'($urandom));
	endtask

	// wait until every pending result is out and the block has gone quiet
	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic refuse, input logic [15:0] enq_t,
		input logic [15:0] wait_t, input logic [15:0] byte_t, input logic [15:0] slim_t,
		input logic [15:0] sack_t);
		logic [15:0] vals [6];
		vals = '{16'(refuse), enq_t, wait_t, byte_t, slim_t, sack_t};
		settle();
		for (int i = REG_REFUSE; i <= REG_START_ACK; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= 3'(i);
			cfg.data  <= vals[i];
			@(posedge clk);
			while (!cfg.ready) @(posedge clk);
		end
		cfg.valid <= 1'b0;
	endtask

	function automatic int unsigned ticks_past(input logic [15:0] lim);
		return (lim > 16'd60) ? 61 : int'(lim) + 1;
	endfunction

	task automatic send_frame();
		int unsigned len;
		int unsigned cut;
		logic [15:0] crc;
		logic [7:0]  b;
		len = ($urandom_range(0, 24) == 0) ? $urandom_range(REQ_MAX - 2, REQ_MAX + 1)
			: $urandom_range(0, 10);
		// now and then a sub lands inside the frame
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : len + 1;
		crc = '0;
		send_event(KIND_BYTE, CH_ACK);
		if ($urandom_range(0, 3) == 0)
			send_event(KIND_BYTE, CH_ACK);
		for (int unsigned i = 0; i < len; i++) begin
			if (i == cut)
				send_event(KIND_BYTE, CH_SUB);
			b = 8'($urandom);
			if (b == CH_ETX || b == CH_SUB || (i == 0 && b == CH_ACK))
				b = b | 8'h80;
			crc = crc_update(crc, b);
			send_event(KIND_BYTE, b);
			if ($urandom_range(0, 7) == 0)
				send_event(KIND_TICK, 8'($urandom));
		end
		send_event(KIND_BYTE, CH_ETX);
		if ($urandom_range(0, 7) == 0)
			crc = crc ^ (16'd1 << $urandom_range(0, 15));
		send_event(KIND_BYTE, crc[7:0]);
		send_event(KIND_BYTE, crc[15:8]);
	endtask

	task automatic run_session();
		int unsigned rounds;
		if ($urandom_range(0, 3) == 0)
			send_event(KIND_CARRIER, 8'($urandom));
		if ($urandom_range(0, 7) == 0)
			send_noise($urandom_range(1, 6));
		send_event(KIND_START, 8'($urandom));
		rounds = $urandom_range(1, 3);
		repeat (rounds) begin
			send_ticks($urandom_range(0, 2));
			if ($urandom_range(0, 3) == 0)
				send_event(KIND_BYTE, CH_ENQ);
			if ($urandom_range(0, 9) == 0)
				send_noise($urandom_range(1, 4));
			send_frame();
			send_ticks($urandom_range(0, 2));
			if ($urandom_range(0, 2) == 0)
				send_event(KIND_BYTE, 8'($urandom));
			if ($urandom_range(0, 9) == 0)
				send_ticks(ticks_past(reg_start_lim));
			else
				send_event(KIND_BYTE, $urandom_range(0, 1) ? CH_C : CH_NAK);
			send_event(KIND_FINISH, 8'($urandom));
		end
		case ($urandom_range(0, 3))
		0: send_event(KIND_BYTE, CH_ETB);
		1: send_event(KIND_CARRIER, 8'($urandom));
		2: send_ticks(ticks_past(reg_wait_limit));
		default: ;
		endcase
	endtask

	task automatic test_idle_and_handshake();
		send_event(KIND_TICK, 8'hff);
		send_event(KIND_BYTE, 8'h00);
		send_event(KIND_FINISH, 8'h00);
		send_event(KIND_CARRIER, 8'hff);
		for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
			send_event(3'(k), 8'hff);
		send_event(KIND_START, 8'h00);
		send_event(KIND_START, 8'h00);
		send_event(KIND_BYTE, CH_ENQ);
		send_event(KIND_TICK, 8'h00);
		send_event(KIND_BYTE, CH_ETB);
	endtask

	task automatic test_good_request();
		logic [7:0]  body [3];
		logic [15:0] crc;
		body = '{8'h00, 8'hff, CH_C};
		crc  = '0;
		foreach (body[i])
			crc = crc_update(crc, body[i]);
		send_event(KIND_START, 8'h00);
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_BYTE, CH_ACK);
		foreach (body[i])
			send_event(KIND_BYTE, body[i]);
		send_event(KIND_BYTE, CH_ETX);
		send_event(KIND_BYTE, crc[7:0]);
		send_event(KIND_BYTE, crc[15:8]);
		send_event(KIND_BYTE, 8'h00);
		send_event(KIND_BYTE, CH_NAK);
		send_event(KIND_FINISH, 8'h00);
		send_event(KIND_CARRIER, 8'h00);
	endtask

	task automatic test_frame_errors();
		logic [15:0] crc;
		crc = crc_update(16'h0000, 8'h41);
		send_event(KIND_START, 8'h00);
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_BYTE, 8'h41);
		send_event(KIND_BYTE, CH_SUB);
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_BYTE, 8'h41);
		send_event(KIND_BYTE, CH_ETX);
		send_event(KIND_BYTE, crc[7:0]);
		send_event(KIND_BYTE, crc[15:8] ^ 8'h01);
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_BYTE, 8'h42);
		send_event(KIND_BYTE, CH_ETX);
		send_event(KIND_CARRIER, 8'h00);
	endtask

	task automatic test_refusal();
		program_regs(1'b1, RST_ENQ_RESEND, RST_WAIT_LIMIT, RST_BYTE_TMO, RST_START_LIM,
			RST_START_ACK);
		send_event(KIND_START, 8'h00);
		send_event(KIND_START, 8'h00);
		program_regs(1'b0, RST_ENQ_RESEND, RST_WAIT_LIMIT, RST_BYTE_TMO, RST_START_LIM,
			RST_START_ACK);
		send_event(KIND_START, 8'h00);
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_BYTE, 8'h10);
		// refusal turned on mid-frame: the discard gives way to the refusal
		program_regs(1'b1, RST_ENQ_RESEND, RST_WAIT_LIMIT, RST_BYTE_TMO, RST_START_LIM,
			RST_START_ACK);
		send_event(KIND_BYTE, CH_SUB);
	endtask

	task automatic test_timer_limits();
		program_regs(1'b0, 16'd2, 16'd5, 16'd1, 16'd4, 16'd2);
		send_event(KIND_START, 8'h00);
		send_ticks(5);
		send_event(KIND_START, 8'h00);
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_TICK, 8'h00);
		// empty frame, crc of zero
		send_event(KIND_BYTE, CH_ACK);
		send_event(KIND_BYTE, CH_ETX);
		send_event(KIND_BYTE, 8'h00);
		send_event(KIND_BYTE, 8'h00);
		send_ticks(4);
		program_regs(1'b0, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX);
		send_event(KIND_START, 8'h00);
		send_ticks(3);
		send_event(KIND_CARRIER, 8'h00);
		// wait limit wins over the resend when both fall due
		program_regs(1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		send_event(KIND_START, 8'h00);
		send_event(KIND_TICK, 8'h00);
	endtask

	task automatic test_random_sessions(input int unsigned stop_at);
		int unsigned phase_end;
		int unsigned round_no;
		logic        refuse;
		round_no = 0;
		while (n_events < stop_at) begin
			refuse = (round_no % 6 == 5);
			case (round_no % 6)
			0: program_regs(1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
			1: program_regs(1'b0, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX);
			default: program_regs(refuse, 16'($urandom_range(1, 6)), 16'($urandom_range(4, 80)),
				16'($urandom_range(2, 10)), 16'($urandom_range(3, 40)), 16'($urandom_range(1, 8)));
			endcase
			idle_mode = ($urandom_range(0, 3) != 0);
			phase_end = n_events + (refuse ? 40 : 150);
			while (n_events < phase_end && n_events < stop_at)
				run_session();
			round_no++;
		end
	endtask

	task automatic test_steady_stream(input int unsigned stop_at);
		idle_mode = 1'b0;
		program_regs(1'b0, 16'($urandom_range(1, 6)), 16'($urandom_range(4, 80)),
			16'($urandom_range(2, 10)), 16'($urandom_range(3, 40)), 16'($urandom_range(1, 8)));
		while (n_events < stop_at)
			run_session();
	endtask

	initial begin
		int unsigned waited;
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.kind    <= KIND_BYTE;
		req.rx_byte <= 8'h00;
		cfg.valid   <= 1'b0;
		cfg.index   <= REG_REFUSE;
		cfg.data    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_handshake();
		test_good_request();
		test_frame_errors();
		test_refusal();
		test_timer_limits();
		test_random_sessions(RANDOM_UNTIL);
		test_steady_stream(STEADY_UNTIL);

		req.valid <= 1'b0;
		waited = 0;
		while (expected_rsp.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch("results still pending, count", 0, expected_rsp.size());

		$display("covered %0d events, %0d result beats, %0d register writes",
			n_events, n_results, n_writes);
		$display("requests: %0d accepted, %0d discarded, %0d served",
			n_good, n_discard, n_serve);
		if (errors == 0)
			$display("file_request_receiver regression: pass");
		else
			$display("file_request_receiver regression: fail");
		$finish;
	end

endmodule

// File: files.f
rtl/frr_pkg.sv
rtl/frr_if.sv
rtl/frr_engine.sv
rtl/frr_queue.sv
rtl/frr_drain.sv
rtl/file_request_receiver.sv
test/file_request_receiver_test.sv
